// File: src/ilff_pkg.sv
// ----------------------------------------------------------------------------
// ilff_pkg: shared types for the first-fit heap allocator
// Request and result payloads and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ilff_pkg;

    localparam int unsigned REQ_W   = 17;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned INIT_G  = 512;   // initial heap of 4096 bytes, in granules
    localparam int unsigned HDR_RND = 11;    // 4 header bytes plus 7 for rounding up

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        logic              success;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FREE_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_WALK_RD,
        S_WALK_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_ADV,
        S_FIT,
        S_GROW_A,
        S_GROW_B,
        S_GROW_C,
        S_GROW_D,
        S_GROW_W1,
        S_GROW_W2,
        S_GROW_W3,
        S_SPLIT_A,
        S_SPLIT_B,
        S_DONE
    } t_state;

endpackage

// File: src/ilff_alu.sv
// ----------------------------------------------------------------------------
// ilff_alu: shared add, subtract and compare unit
// One adder and one subtractor whose operands the sequencer picks each cycle.
// ----------------------------------------------------------------------------
module ilff_alu #(
    parameter int unsigned CW = 18
) (
    input  logic [CW-1:0] i_a,
    input  logic [CW-1:0] i_b,
    output logic [CW-1:0] o_sum,
    output logic [CW-1:0] o_diff,
    output logic          o_lt,
    output logic          o_eq
);
    logic [CW:0] w_sub;

    assign o_sum  = i_a + i_b;
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_sub[CW-1:0];
    assign o_lt   = w_sub[CW];
    assign o_eq   = (i_a == i_b);
endmodule

// File: src/ilff_hdr_ram.sv
// ----------------------------------------------------------------------------
// ilff_hdr_ram: block header memory
// One header per granule, single port with a registered read. After reset a
// clearing pass writes the initial heap image, one entry per cycle.
// ----------------------------------------------------------------------------
module ilff_hdr_ram
    import ilff_pkg::*;
#(
    parameter int unsigned SLOTS = 8192,
    parameter int unsigned AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [AW+1:0] i_wdata,
    output logic [AW+1:0] o_rdata,
    output logic          o_busy
);
    logic [AW+1:0] r_mem [SLOTS];
    logic [AW+1:0] r_rdata;
    logic          r_busy;
    logic [AW-1:0] r_clr_idx;
    logic [AW+1:0] w_init;

    always_comb begin
        if (r_clr_idx == AW'(0)) begin
            w_init = {(AW+1)'(INIT_G), 1'b0};
        end else if (r_clr_idx == AW'(INIT_G)) begin
            w_init = {{(AW+1){1'b0}}, 1'b1};
        end else begin
            w_init = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(SLOTS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= w_init;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_we) else $error("header write during clearing pass");
endmodule

// File: src/ilff_seq.sv
// ----------------------------------------------------------------------------
// ilff_seq: allocator sequencer
// Walks, merges, grows and splits blocks with at most one header access per cycle,
// using the shared arithmetic unit for every add and every magnitude compare.
// ----------------------------------------------------------------------------
module ilff_seq
    import ilff_pkg::*;
#(
    parameter int unsigned AW      = 13,
    parameter int unsigned CW      = 18,
    parameter int unsigned GMIN_G  = 512,
    parameter int unsigned LIMIT_G = 8191
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_item      i_in,
    input  logic          i_ram_busy,
    output logic          o_we,
    output logic [AW-1:0] o_addr,
    output logic [AW+1:0] o_wdata,
    input  logic [AW+1:0] i_rdata,
    input  logic          i_out_free,
    output logic          o_done,
    output t_out_item     o_res
);
    t_state  r_state, n_state;
    logic [CW-1:0] r_heap_end, r_cur, r_sz, r_nxt, r_need, r_prev, r_prev_sz, r_grow;
    logic r_prev_free, r_ok, r_is_free;
    logic [CW-1:0] w_a, w_b, w_sum, w_diff;
    logic w_lt, w_eq;
    logic [CW-1:0] w_rsize;
    logic w_ralloc, w_accept;

    assign w_rsize  = CW'(i_rdata[AW+1:1]);
    assign w_ralloc = i_rdata[0];
    assign w_accept = i_in_valid && o_in_ready;

    ilff_alu #(.CW(CW)) u_alu (
        .i_a(w_a), .i_b(w_b), .o_sum(w_sum), .o_diff(w_diff), .o_lt(w_lt), .o_eq(w_eq)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.mode == MODE_FREE) begin
                        n_state = (i_in.free_address[2:0] == 3'd4) ? S_FREE_CHK : S_DONE;
                    end else begin
                        n_state = (i_in.request_bytes == '0) ? S_DONE : S_WALK_RD;
                    end
                end
            end
            S_FREE_CHK:  n_state = w_lt ? S_FREE_RD : S_DONE;
            S_FREE_RD:   n_state = S_FREE_WR;
            S_FREE_WR:   n_state = S_DONE;
            S_WALK_RD:   n_state = w_lt ? S_WALK_CHK : S_GROW_A;
            S_WALK_CHK: begin
                if (w_rsize == '0) begin
                    n_state = S_GROW_A;
                end else if (w_ralloc) begin
                    n_state = S_WALK_RD;
                end else begin
                    n_state = S_MERGE_RD;
                end
            end
            S_MERGE_RD:  n_state = w_lt ? S_MERGE_CHK : S_FIT;
            S_MERGE_CHK: n_state = (!w_ralloc && w_rsize != '0) ? S_MERGE_ADV : S_FIT;
            S_MERGE_ADV: n_state = S_MERGE_RD;
            S_FIT:       n_state = w_lt ? S_WALK_RD : S_SPLIT_A;
            S_GROW_A:    n_state = S_GROW_B;
            S_GROW_B:    n_state = S_GROW_C;
            S_GROW_C:    n_state = S_GROW_D;
            S_GROW_D:    n_state = w_lt ? S_DONE : S_GROW_W1;
            S_GROW_W1:   n_state = S_GROW_W2;
            S_GROW_W2:   n_state = S_GROW_W3;
            S_GROW_W3:   n_state = S_SPLIT_A;
            S_SPLIT_A:   n_state = S_SPLIT_B;
            S_SPLIT_B:   n_state = S_DONE;
            S_DONE:      n_state = i_out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Operand selection, memory port and handshake.
    always_comb begin
        w_a        = '0;
        w_b        = '0;
        o_we       = 1'b0;
        o_addr     = r_cur[AW-1:0];
        o_wdata    = '0;
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_ram_busy;
                w_a = CW'(i_in.request_bytes);
                w_b = CW'(HDR_RND);
            end
            S_FREE_CHK: begin
                w_a = r_cur;
                w_b = r_heap_end;
            end
            S_FREE_RD: o_addr = r_cur[AW-1:0];
            S_FREE_WR: begin
                o_we    = 1'b1;
                o_wdata = {i_rdata[AW+1:1], 1'b0};
            end
            S_WALK_RD: begin
                w_a = r_cur;
                w_b = r_heap_end;
            end
            S_WALK_CHK: begin
                w_a = r_cur;
                w_b = w_rsize;
            end
            S_MERGE_RD: begin
                o_addr = r_nxt[AW-1:0];
                w_a = r_nxt;
                w_b = r_heap_end;
            end
            S_MERGE_CHK: begin
                w_a = r_sz;
                w_b = w_rsize;
                o_we    = !w_ralloc && w_rsize != '0;
                o_wdata = {w_sum[AW:0], 1'b0};
            end
            S_MERGE_ADV: begin
                w_a = r_cur;
                w_b = r_sz;
            end
            S_FIT: begin
                w_a = r_sz;
                w_b = r_need;
            end
            S_GROW_A: begin
                w_a = r_need;
                w_b = r_prev_sz;
            end
            S_GROW_B: begin
                w_a = r_grow;
                w_b = CW'(GMIN_G);
            end
            S_GROW_C: begin
                w_a = r_heap_end;
                w_b = r_grow;
            end
            S_GROW_D: begin
                w_a = CW'(LIMIT_G);
                w_b = r_nxt;
            end
            S_GROW_W1: begin
                o_we    = 1'b1;
                o_addr  = r_heap_end[AW-1:0];
                o_wdata = {r_grow[AW:0], 1'b0};
            end
            S_GROW_W2: begin
                o_we    = 1'b1;
                o_addr  = r_nxt[AW-1:0];
                o_wdata = {{(AW+1){1'b0}}, 1'b1};
            end
            S_GROW_W3: begin
                w_a = r_prev_sz;
                w_b = r_grow;
                o_we    = r_prev_free;
                o_addr  = r_prev[AW-1:0];
                o_wdata = {w_sum[AW:0], 1'b0};
            end
            S_SPLIT_A: begin
                w_a = r_cur;
                w_b = r_need;
                o_we    = 1'b1;
                o_wdata = {r_need[AW:0], 1'b1};
            end
            S_SPLIT_B: begin
                w_a = r_sz;
                w_b = r_need;
                o_we    = !w_lt && !w_eq;
                o_addr  = r_nxt[AW-1:0];
                o_wdata = {w_diff[AW:0], 1'b0};
            end
            S_DONE: o_done = i_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_heap_end <= CW'(INIT_G);
        end else begin
            r_state <= n_state;
            if (r_state == S_GROW_W3) begin
                r_heap_end <= r_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_is_free   <= (i_in.mode == MODE_FREE);
                r_ok        <= 1'b0;
                r_need      <= w_sum >> 3;
                r_prev_free <= 1'b0;
                r_prev_sz   <= '0;
                r_prev      <= '0;
                r_cur       <= (i_in.mode == MODE_FREE) ? CW'(i_in.free_address[ADDR_W-1:3])
                                                        : '0;
            end
            S_FREE_WR: r_ok <= 1'b1;
            S_WALK_CHK: begin
                r_sz <= w_rsize;
                if (w_ralloc) begin
                    r_prev      <= r_cur;
                    r_prev_free <= 1'b0;
                    r_cur       <= w_sum;
                end else begin
                    r_nxt <= w_sum;
                end
            end
            S_MERGE_CHK: begin
                if (!w_ralloc && w_rsize != '0) begin
                    r_sz <= w_sum;
                end
            end
            S_MERGE_ADV: r_nxt <= w_sum;
            S_FIT: begin
                if (w_lt) begin
                    r_prev      <= r_cur;
                    r_prev_free <= 1'b1;
                    r_prev_sz   <= r_sz;
                    r_cur       <= r_nxt;
                end
            end
            S_GROW_A: r_grow <= (r_prev_free && !w_lt && !w_eq) ? w_diff : r_need;
            S_GROW_B: begin
                if (w_lt) begin
                    r_grow <= CW'(GMIN_G);
                end
            end
            S_GROW_C: r_nxt <= w_sum;
            S_GROW_W3: begin
                if (r_prev_free) begin
                    r_cur <= r_prev;
                    r_sz  <= w_sum;
                end else begin
                    r_cur <= r_heap_end;
                    r_sz  <= r_grow;
                end
            end
            S_SPLIT_A: r_nxt <= w_sum;
            S_SPLIT_B: r_ok <= 1'b1;
            default: ;
        endcase
    end

    logic [AW+2:0] w_byte_addr;
    assign w_byte_addr = {r_cur[AW-1:0], 3'b100};

    always_comb begin
        o_res.success         = r_ok;
        o_res.payload_address = (r_ok && !r_is_free) ? ADDR_W'(w_byte_addr) : '0;
    end

    a_heap_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heap_end <= CW'(LIMIT_G)) else $error("heap end past capacity");
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_CHK) |-> ($past(r_state) == S_WALK_RD))
        else $error("header check without a read");
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_ok && !r_is_free) |-> (w_byte_addr[2:0] == 3'd4))
        else $error("misaligned payload address");
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_we) else $error("header write while idle");
endmodule

// File: src/implicit_list_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator: first-fit heap allocator, top level
// Free checks the address, reads the header and writes it back marked free; a
// rejected address goes straight to the result. Allocate walks past allocated
// blocks, merges each free block with the free blocks after it, then splits or grows.
// Every header access goes through the single port of the header memory.
// One request at a time; the result waits in an output register.
// Reset is synchronous; a clearing pass over all HEAP_BYTES/8 header slots follows it.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator
    import ilff_pkg::*;
#(
    parameter int unsigned HEAP_BYTES     = 65536,
    parameter int unsigned GROW_MIN_BYTES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);
    localparam int unsigned SLOTS   = HEAP_BYTES / 8;
    localparam int unsigned AW      = $clog2(SLOTS);
    localparam int unsigned CW      = ((AW > 16) ? AW : 16) + 2;
    localparam int unsigned GMIN_G  = (GROW_MIN_BYTES + 7) / 8;
    localparam int unsigned LIMIT_G = (HEAP_BYTES - 4) / 8;

    logic          w_we, w_busy, w_done, w_out_free;
    logic [AW-1:0] w_addr;
    logic [AW+1:0] w_wdata, w_rdata;
    t_out_item     w_res;
    logic          r_out_valid;
    t_out_item     r_out;

    assign w_out_free = !r_out_valid || i_out_ready;

    ilff_hdr_ram #(.SLOTS(SLOTS), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_wdata), .o_rdata(w_rdata), .o_busy(w_busy)
    );

    ilff_seq #(.AW(AW), .CW(CW), .GMIN_G(GMIN_G), .LIMIT_G(LIMIT_G)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_in(i_in), .i_ram_busy(w_busy),
        .o_we(w_we), .o_addr(w_addr), .o_wdata(w_wdata), .i_rdata(w_rdata),
        .i_out_free(w_out_free), .o_done(w_done), .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
